FILE: rtl/kpd_pkg.sv
// Package for the key-exchange MAC payload deframer.
// Holds the phase type, field codes, error codes, register indexes and sizes.
// No dependencies; every other file imports it.
package kpd_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int KIND_W  = 3;
    localparam int ERR_W   = 2;
    localparam int CIDX_W  = 8;

    // Number of MAC bytes after an HMAC algorithm byte
    localparam logic [LEN_W-1:0] MAC_BYTES = LEN_W'(20);

    // Field expected next; the value doubles as the field kind of the item
    typedef enum logic [KIND_W-1:0] {
        PH_NEXT   = 3'd0,
        PH_ENCR   = 3'd1,
        PH_LENHI  = 3'd2,
        PH_LENLO  = 3'd3,
        PH_DATA   = 3'd4,
        PH_MACALG = 3'd5,
        PH_MAC    = 3'd6,
        PH_TRAIL  = 3'd7
    } t_phase;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_SHORT   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_MAC_ALG = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_IDX_HMAC = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_IDX_NULL = 8'd1;

    // Register reset values
    localparam logic [BYTE_W-1:0] HMAC_CODE_RST = 8'd1;
    localparam logic [BYTE_W-1:0] NULL_CODE_RST = 8'd0;

    // Configuration handed to the parser
    typedef struct packed {
        logic [BYTE_W-1:0] hmac_code;
        logic [BYTE_W-1:0] null_code;
    } t_cfg;

endpackage

FILE: rtl/kemac_payload_deframer_top.sv
// A result is registered and valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the result register is refilled in the cycle it is
// taken, so input ready drops only while a result waits and output ready is low.
// Reset (synchronous, active low): parse state to the next-type field, length and count
// to zero, result register empty, HMAC code to 1 and null MAC code to 0.
// Configuration writes are always ready; the parser and registers are kpd_* modules.
module kemac_payload_deframer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [kpd_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [kpd_pkg::BYTE_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [kpd_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_buffer_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [kpd_pkg::KIND_W-1:0]  o_field_kind,
    output logic [kpd_pkg::BYTE_W-1:0]  o_byte_value,
    output logic [kpd_pkg::LEN_W-1:0]   o_index_in_field,
    output logic                        o_payload_end,
    output logic [kpd_pkg::LEN_W-1:0]   o_data_length,
    output logic [kpd_pkg::ERR_W-1:0]   o_error_code
);
    import kpd_pkg::*;

    t_cfg cfg;

    // Algorithm code registers
    kpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Byte tagger
    kpd_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_buffer_last    (i_buffer_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_field_kind     (o_field_kind),
        .o_byte_value     (o_byte_value),
        .o_index_in_field (o_index_in_field),
        .o_payload_end    (o_payload_end),
        .o_data_length    (o_data_length),
        .o_error_code     (o_error_code)
    );

endmodule

FILE: rtl/kpd_cfg_regs.sv
// Configuration registers of the deframer: HMAC and null MAC algorithm codes.
// Depends on kpd_pkg for indexes, reset values and the t_cfg struct.
module kpd_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [kpd_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [kpd_pkg::BYTE_W-1:0]  i_cfg_data,
    output kpd_pkg::t_cfg               o_cfg
);
    import kpd_pkg::*;

    logic [BYTE_W-1:0] r_hmac_code;
    logic [BYTE_W-1:0] r_null_code;
    logic              wr;

    // Take every write at once
    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid && o_cfg_ready;

    // Store the addressed register; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hmac_code <= HMAC_CODE_RST;
            r_null_code <= NULL_CODE_RST;
        end else if (wr) begin
            if (i_cfg_index == CFG_IDX_HMAC) begin
                r_hmac_code <= i_cfg_data;
            end
            if (i_cfg_index == CFG_IDX_NULL) begin
                r_null_code <= i_cfg_data;
            end
        end
    end

    assign o_cfg.hmac_code = r_hmac_code;
    assign o_cfg.null_code = r_null_code;

endmodule

FILE: rtl/kpd_parser.sv
// Phase tracker and result register of the deframer: tags each byte in one pass.
// Depends on kpd_pkg for the phase type, codes and sizes.
module kpd_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kpd_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [kpd_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_buffer_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [kpd_pkg::KIND_W-1:0]  o_field_kind,
    output logic [kpd_pkg::BYTE_W-1:0]  o_byte_value,
    output logic [kpd_pkg::LEN_W-1:0]   o_index_in_field,
    output logic                        o_payload_end,
    output logic [kpd_pkg::LEN_W-1:0]   o_data_length,
    output logic [kpd_pkg::ERR_W-1:0]   o_error_code
);
    import kpd_pkg::*;

    // Parse state
    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_field_count, n_field_count;
    logic [LEN_W-1:0]  r_length, n_length;

    // Result register
    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [BYTE_W-1:0] r_byte;
    logic [LEN_W-1:0]  r_index;
    logic              r_end;
    logic [LEN_W-1:0]  r_dlen;
    logic [ERR_W-1:0]  r_err;

    // Result of the current byte
    logic [KIND_W-1:0] res_kind;
    logic [LEN_W-1:0]  res_index;
    logic              res_end;
    logic [LEN_W-1:0]  res_dlen;
    logic [ERR_W-1:0]  res_err;

    logic              acc;
    logic [LEN_W:0]    cnt_inc;
    logic [LEN_W-1:0]  len_full;

    // Accept while the result register is empty or being emptied
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign acc        = i_in_valid && o_in_ready;

    assign cnt_inc  = {1'b0, r_field_count} + {{LEN_W{1'b0}}, 1'b1};
    assign len_full = {r_length[LEN_W-1:BYTE_W], i_data_byte};

    // Next state
    always_comb begin
        n_phase       = r_phase;
        n_field_count = r_field_count;
        n_length      = r_length;
        case (r_phase)
            PH_NEXT:  n_phase = PH_ENCR;
            PH_ENCR:  n_phase = PH_LENHI;
            PH_LENHI: begin
                n_length = {i_data_byte, {BYTE_W{1'b0}}};
                n_phase  = PH_LENLO;
            end
            PH_LENLO: begin
                n_length      = len_full;
                n_field_count = '0;
                n_phase       = (len_full == '0) ? PH_MACALG : PH_DATA;
            end
            PH_DATA: begin
                n_field_count = cnt_inc[LEN_W-1:0];
                if (cnt_inc >= {1'b0, r_length}) begin
                    n_field_count = '0;
                    n_phase       = PH_MACALG;
                end
            end
            PH_MACALG: begin
                n_field_count = '0;
                n_phase = (i_data_byte == i_cfg.hmac_code) ? PH_MAC : PH_TRAIL;
            end
            PH_MAC: begin
                n_field_count = cnt_inc[LEN_W-1:0];
                if (cnt_inc >= {1'b0, MAC_BYTES}) begin
                    n_field_count = '0;
                    n_phase       = PH_TRAIL;
                end
            end
            default: n_phase = PH_TRAIL;
        endcase
        // Start afresh after the last byte of the buffer
        if (i_buffer_last) begin
            n_phase       = PH_NEXT;
            n_field_count = '0;
            n_length      = '0;
        end
    end

    // Result fields
    always_comb begin
        res_kind  = r_phase;
        res_index = '0;
        res_end   = 1'b0;
        res_dlen  = '0;
        res_err   = ERR_NONE;
        case (r_phase)
            PH_NEXT, PH_ENCR, PH_LENHI: ;
            PH_LENLO: res_dlen = len_full;
            PH_DATA: begin
                res_index = r_field_count;
                res_dlen  = r_length;
            end
            PH_MACALG: begin
                res_dlen = r_length;
                if (i_data_byte == i_cfg.hmac_code) begin
                    res_end = 1'b0;
                end else if (i_data_byte == i_cfg.null_code) begin
                    res_end = 1'b1;
                end else begin
                    res_err = ERR_MAC_ALG;
                end
            end
            PH_MAC: begin
                res_index = r_field_count;
                res_dlen  = r_length;
                res_end   = (cnt_inc >= {1'b0, MAC_BYTES});
            end
            default: res_dlen = r_length;
        endcase
        // Flag a buffer that ends inside the payload
        if (i_buffer_last && !res_end && res_err == ERR_NONE && r_phase != PH_TRAIL) begin
            res_err = ERR_SHORT;
        end
    end

    // Advance the parse state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_NEXT;
            r_field_count <= '0;
            r_length      <= '0;
        end else if (acc) begin
            r_phase       <= n_phase;
            r_field_count <= n_field_count;
            r_length      <= n_length;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_kind  <= res_kind;
            r_byte  <= i_data_byte;
            r_index <= res_index;
            r_end   <= res_end;
            r_dlen  <= res_dlen;
            r_err   <= res_err;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_field_kind     = r_kind;
    assign o_byte_value     = r_byte;
    assign o_index_in_field = r_index;
    assign o_payload_end    = r_end;
    assign o_data_length    = r_dlen;
    assign o_error_code     = r_err;

    // The data counter never reaches the decoded length
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_field_count < r_length)
        else $error("data counter at or beyond length");

    // A buffer end always returns the tracker to the first field
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_buffer_last |=> r_phase == PH_NEXT && r_length == '0)
        else $error("state not cleared after last byte");

    // An unknown algorithm is reported only on the algorithm byte
    a_alg_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code == ERR_MAC_ALG |-> o_field_kind == PH_MACALG)
        else $error("algorithm error on wrong field");

    // A completed payload carries no error
    a_end_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_end |-> o_error_code == ERR_NONE)
        else $error("payload end with error");

    // Only data and MAC bytes carry an index
    a_index_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_in_field != '0 |->
            o_field_kind == PH_DATA || o_field_kind == PH_MAC)
        else $error("index on a fixed field");

endmodule
